// ===== hw/rtl/svpwm_pkg.sv =====
// svpwm_pkg: shared constants, sector codes and lookup functions for the
// space vector pwm duty generator. no dependencies.
`timescale 1ns / 1ps

package svpwm_pkg;

	localparam int VOLT_WIDTH_DEF  = 16;
	localparam int DUTY_FRAC_DEF   = 15;
	localparam int BUS_W           = 14;
	localparam int SECTOR_W        = 3;
	localparam int DUTY_W          = 16;
	localparam int QUEUE_DEPTH     = 2;
	localparam int SQRT3_Q16       = 113512;
	localparam logic [BUS_W-1:0] BUS_RESET = 14'd3072;

	localparam logic [SECTOR_W-1:0] SECTOR_1 = 3'd1;
	localparam logic [SECTOR_W-1:0] SECTOR_2 = 3'd2;
	localparam logic [SECTOR_W-1:0] SECTOR_3 = 3'd3;
	localparam logic [SECTOR_W-1:0] SECTOR_4 = 3'd4;
	localparam logic [SECTOR_W-1:0] SECTOR_5 = 3'd5;
	localparam logic [SECTOR_W-1:0] SECTOR_6 = 3'd6;

	// sign code (a = bit 0, b = bit 1, c = bit 2) to sector
	function automatic logic [SECTOR_W-1:0] sector_of_code(input logic [2:0] code);
		logic [SECTOR_W-1:0] s;
		case (code)
			3'd2:    s = SECTOR_6;
			3'd3:    s = SECTOR_1;
			3'd4:    s = SECTOR_4;
			3'd5:    s = SECTOR_3;
			3'd6:    s = SECTOR_5;
			default: s = SECTOR_2; // codes 0, 1 and 7
		endcase
		return s;
	endfunction

	// which switching point (0..2) drives phase k in a sector
	function automatic logic [1:0] route_idx(input logic [SECTOR_W-1:0] sec,
		input logic [1:0] k);
		logic [5:0] row;
		case (sec)
			SECTOR_1: row = {2'd2, 2'd1, 2'd0};
			SECTOR_2: row = {2'd2, 2'd0, 2'd1};
			SECTOR_3: row = {2'd1, 2'd0, 2'd2};
			SECTOR_4: row = {2'd0, 2'd1, 2'd2};
			SECTOR_5: row = {2'd0, 2'd2, 2'd1};
			default:  row = {2'd1, 2'd2, 2'd0};
		endcase
		case (k)
			2'd0:    return row[1:0];
			2'd1:    return row[3:2];
			default: return row[5:4];
		endcase
	endfunction

endpackage

// ===== hw/rtl/svpwm_div.sv =====
// svpwm_div: restoring divider, one quotient bit per cycle.
// depends on nothing.
`timescale 1ns / 1ps

module svpwm_div #(
	parameter int W  = 33,
	parameter int NB = 19
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  rem_init,
	input  logic [W-1:0]  divisor,
	input  logic [NB-1:0] num_bits,
	output logic          busy,
	output logic [NB-1:0] quot
);

	localparam int CW = $clog2(NB + 1);

	logic [W-1:0]  rem_q;
	logic [W-1:0]  den_q;
	logic [NB-1:0] nb_q;
	logic [NB-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic [W:0]    rs;
	logic          ge;

	assign rs   = {rem_q, nb_q[NB-1]};
	assign ge   = rs >= {1'b0, den_q};
	assign busy = cnt_q != '0;
	assign quot = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NB);
		end else if (busy) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			den_q <= divisor;
			nb_q  <= num_bits;
		end else if (busy) begin
			rem_q <= ge ? W'(rs - {1'b0, den_q}) : W'(rs);
			nb_q  <= {nb_q[NB-2:0], 1'b0};
			quo_q <= {quo_q[NB-2:0], ge};
		end
	end

endmodule

// ===== hw/rtl/svpwm_queue.sv =====
// svpwm_queue: small register queue between classifier and time engine.
// depends on nothing.
`timescale 1ns / 1ps

module svpwm_queue #(
	parameter int W     = 73,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	output logic         full,
	input  logic         rd,
	output logic         valid,
	output logic [W-1:0] rdata
);

	localparam int PTW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CTW = $clog2(DEPTH + 1);

	logic [W-1:0]   mem_q [DEPTH];
	logic [PTW-1:0] wp_q;
	logic [PTW-1:0] rp_q;
	logic [CTW-1:0] cnt_q;
	logic           do_wr;
	logic           do_rd;

	assign full  = cnt_q == CTW'(DEPTH);
	assign valid = cnt_q != '0;
	assign rdata = mem_q[rp_q];
	assign do_wr = wr && !full;
	assign do_rd = rd && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wp_q <= (wp_q == PTW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (do_rd) begin
				rp_q <= (rp_q == PTW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule

// ===== hw/rtl/svpwm_front.sv =====
// svpwm_front: projects the voltage vector on three axes, finds the sector
// and picks the two projections. uses svpwm_pkg.
`timescale 1ns / 1ps

module svpwm_front
	import svpwm_pkg::*;
#(
	parameter int VOLT_WIDTH = VOLT_WIDTH_DEF,
	parameter int PW         = VOLT_WIDTH + 19
) (
	input  logic signed [VOLT_WIDTH-1:0] volt_alpha,
	input  logic signed [VOLT_WIDTH-1:0] volt_beta,
	output logic [SECTOR_W-1:0]          sector,
	output logic signed [PW-1:0]         proj1,
	output logic signed [PW-1:0]         proj2
);

	localparam int MW = VOLT_WIDTH + 18;

	logic signed [MW-1:0] prod;
	logic signed [PW-1:0] sa;
	logic signed [PW-1:0] be_x;
	logic signed [PW-1:0] b16;
	logic signed [PW-1:0] pa;
	logic signed [PW-1:0] pb;
	logic signed [PW-1:0] pc;
	logic [2:0]           code;

	assign prod = volt_alpha * $signed({1'b0, 17'(SQRT3_Q16)});
	assign sa   = PW'(prod);
	assign be_x = PW'(volt_beta);
	assign b16  = be_x <<< 16;
	assign pa   = be_x <<< 17;
	assign pb   = sa - b16;
	assign pc   = -(sa + b16);

	assign code = {(!pc[PW-1] && pc != '0), (!pb[PW-1] && pb != '0),
		(!pa[PW-1] && pa != '0)};
	assign sector = sector_of_code(code);

	always_comb begin
		case (sector)
			SECTOR_1: begin proj1 = pb;  proj2 = pa;  end
			SECTOR_2: begin proj1 = -pb; proj2 = -pc; end
			SECTOR_3: begin proj1 = pa;  proj2 = pc;  end
			SECTOR_4: begin proj1 = -pa; proj2 = -pb; end
			SECTOR_5: begin proj1 = pc;  proj2 = pb;  end
			default:  begin proj1 = -pc; proj2 = -pa; end
		endcase
	end

endmodule

// ===== hw/rtl/svpwm_back.sv =====
// svpwm_back: active-time division, over-modulation limit, duty rounding,
// phase routing and the result register. uses svpwm_pkg and svpwm_div.
`timescale 1ns / 1ps

module svpwm_back
	import svpwm_pkg::*;
#(
	parameter int VOLT_WIDTH     = VOLT_WIDTH_DEF,
	parameter int DUTY_FRAC_BITS = DUTY_FRAC_DEF,
	parameter int PW             = VOLT_WIDTH + 19
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [BUS_W-1:0]      bus,
	input  logic                  q_valid,
	input  logic [SECTOR_W+2*PW-1:0] q_data,
	output logic                  q_pop,
	output logic                  empty,
	input  logic                  pop,
	output logic [SECTOR_W-1:0]   sector,
	output logic [DUTY_W-1:0]     duty_high_a,
	output logic [DUTY_W-1:0]     duty_high_b,
	output logic [DUTY_W-1:0]     duty_high_c,
	output logic                  overmod_limited
);

	localparam int G   = DUTY_FRAC_BITS + 2;
	localparam int TW  = G + 2;
	localparam int SW  = G + 3;
	localparam int NW  = 2 * G + 2;
	localparam int RW1 = BUS_W + 19;
	localparam int CW  = (PW - 1 > RW1) ? PW - 1 : RW1;
	localparam int DW  = G + 5;
	localparam int XW  = DW + DUTY_W;
	localparam logic [G-1:0]  LIM  = G'(((9 << G) + 5) / 10);
	localparam logic [TW-1:0] MAXV = {TW{1'b1}};
	localparam logic [XW-1:0] FULL = XW'(1) << DUTY_FRAC_BITS;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_DIV1 = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_LIM  = 3'd3;
	localparam logic [2:0] ST_DIV2 = 3'd4;
	localparam logic [2:0] ST_OUT  = 3'd5;

	logic [2:0]            state_q;
	logic [SECTOR_W-1:0]   sec_q;
	logic [TW-1:0]         t1_q;
	logic [TW-1:0]         t2_q;
	logic [SW-1:0]         sum_q;
	logic [NW-1:0]         n1_q;
	logic [NW-1:0]         n2_q;
	logic                  flag_q;
	logic [1:0]            force1_q;
	logic [1:0]            force2_q;
	logic                  res_valid_q;
	logic [SECTOR_W-1:0]   res_sec_q;
	logic [DUTY_W-1:0]     res_a_q;
	logic [DUTY_W-1:0]     res_b_q;
	logic [DUTY_W-1:0]     res_c_q;
	logic                  res_flag_q;

	logic [SECTOR_W-1:0]   in_sec;
	logic signed [PW-1:0]  in_p1;
	logic signed [PW-1:0]  in_p2;
	logic [1:0]            f1;
	logic [1:0]            f2;
	logic                  start1;
	logic                  start2;
	logic                  busy1a;
	logic                  busy1b;
	logic                  busy2a;
	logic                  busy2b;
	logic [TW-1:0]         q1a;
	logic [TW-1:0]         q1b;
	logic [G-1:0]          q2a;
	logic [G-1:0]          q2b;
	logic [RW1-1:0]        den4;
	logic [RW1-1:0]        up1;
	logic [RW1-1:0]        up2;
	logic [TW-1:0]         t1_sel;
	logic [TW-1:0]         t2_sel;
	logic signed [DW-1:0]  dpt [3];
	logic [DUTY_W-1:0]     dty [3];
	logic [DUTY_W-1:0]     ph  [3];
	logic                  res_free;

	assign {in_sec, in_p1, in_p2} = q_data;
	assign den4 = {bus, 19'b0};
	assign up1  = RW1'(in_p1);
	assign up2  = RW1'(in_p2);

	// force code: 0 divide, 1 zero, 2 saturate
	function automatic logic [1:0] force_of(input logic signed [PW-1:0] p,
		input logic [BUS_W-1:0] b);
		logic [CW-1:0] up;
		logic [CW-1:0] lim4;
		up   = CW'(p[PW-2:0]);
		lim4 = CW'({b, 19'b0});
		if (p[PW-1] || p == '0) return 2'd1;
		if (b == '0 || up >= lim4) return 2'd2;
		return 2'd0;
	endfunction

	assign f1 = force_of(in_p1, bus);
	assign f2 = force_of(in_p2, bus);

	assign q_pop  = (state_q == ST_IDLE) && q_valid;
	assign start1 = q_pop;
	assign start2 = (state_q == ST_LIM) && (sum_q > SW'(LIM));

	svpwm_div #(.W(RW1), .NB(TW)) u_div1a (
		.clk(clk), .arst_n(arst_n), .start(start1), .rem_init(up1),
		.divisor(den4), .num_bits('0), .busy(busy1a), .quot(q1a)
	);
	svpwm_div #(.W(RW1), .NB(TW)) u_div1b (
		.clk(clk), .arst_n(arst_n), .start(start1), .rem_init(up2),
		.divisor(den4), .num_bits('0), .busy(busy1b), .quot(q1b)
	);
	svpwm_div #(.W(SW), .NB(G)) u_div2a (
		.clk(clk), .arst_n(arst_n), .start(start2), .rem_init(SW'(n1_q[NW-1:G])),
		.divisor(sum_q), .num_bits(n1_q[G-1:0]), .busy(busy2a), .quot(q2a)
	);
	svpwm_div #(.W(SW), .NB(G)) u_div2b (
		.clk(clk), .arst_n(arst_n), .start(start2), .rem_init(SW'(n2_q[NW-1:G])),
		.divisor(sum_q), .num_bits(n2_q[G-1:0]), .busy(busy2b), .quot(q2b)
	);

	always_comb begin
		case (force1_q)
			2'd1:    t1_sel = '0;
			2'd2:    t1_sel = MAXV;
			default: t1_sel = q1a;
		endcase
		case (force2_q)
			2'd1:    t2_sel = '0;
			2'd2:    t2_sel = MAXV;
			default: t2_sel = q1b;
		endcase
	end

	// switching points, rounding to duty format and phase routing
	always_comb begin
		logic signed [DW-1:0] one;
		logic signed [DW-1:0] e1;
		logic signed [DW-1:0] e2;
		logic [XW-1:0]        rr;
		one = DW'(1) <<< G;
		e1  = $signed({{(DW-TW){1'b0}}, t1_q});
		e2  = $signed({{(DW-TW){1'b0}}, t2_q});
		dpt[0] = one + e1 + e2;
		dpt[1] = one - e1 + e2;
		dpt[2] = one - e1 - e2;
		for (int k = 0; k < 3; k++) begin
			if (dpt[k][DW-1]) begin
				rr = '0;
			end else begin
				rr = (XW'(dpt[k]) + XW'(4)) >> 3;
			end
			if (rr > FULL) begin
				rr = FULL;
			end
			dty[k] = rr[DUTY_W-1:0];
		end
		for (int k = 0; k < 3; k++) begin
			ph[k] = dty[route_idx(sec_q, 2'(k))];
		end
	end

	assign res_free = !res_valid_q || pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (q_valid) state_q <= ST_DIV1;
				ST_DIV1: if (!busy1a && !busy1b) state_q <= ST_MUL;
				ST_MUL:  state_q <= ST_LIM;
				ST_LIM:  state_q <= start2 ? ST_DIV2 : ST_OUT;
				ST_DIV2: if (!busy2a && !busy2b) state_q <= ST_OUT;
				ST_OUT: begin
					if (res_free) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sec_q    <= in_sec;
				force1_q <= f1;
				force2_q <= f2;
			end
			ST_DIV1: begin
				t1_q <= t1_sel;
				t2_q <= t2_sel;
			end
			ST_MUL: begin
				sum_q <= SW'(t1_q) + SW'(t2_q);
				n1_q  <= NW'(LIM) * NW'(t1_q);
				n2_q  <= NW'(LIM) * NW'(t2_q);
			end
			ST_LIM: flag_q <= start2;
			ST_DIV2: begin
				t1_q <= TW'(q2a);
				t2_q <= TW'(q2b);
			end
			ST_OUT: begin
				if (res_free) begin
					res_sec_q  <= sec_q;
					res_a_q    <= ph[0];
					res_b_q    <= ph[1];
					res_c_q    <= ph[2];
					res_flag_q <= flag_q;
				end
			end
			default: ;
		endcase
	end

	assign empty           = !res_valid_q;
	assign sector          = res_sec_q;
	assign duty_high_a     = res_a_q;
	assign duty_high_b     = res_b_q;
	assign duty_high_c     = res_c_q;
	assign overmod_limited = res_flag_q;

endmodule

// ===== hw/rtl/svpwm_duty_generator.sv =====
// svpwm_duty_generator: top level of the seven-segment space vector pwm duty
// generator. uses svpwm_pkg, svpwm_front, svpwm_queue and svpwm_back.
//
// usage
// - input channel: drive volt_alpha / volt_beta (signed q8.8) and raise push;
//   an item is taken at a clock edge with push high and full low
// - result channel: while empty is low the oldest result (sector, three
//   high-side duties in q1.15, overmod_limited) sits on the ports; pop takes it
// - bus_voltage (unsigned q6.8) is written through cfg_valid / cfg_ready;
//   cfg_ready is always high, write it only while no item is in flight
// - the front classifies the vector in the accept cycle and parks it in a
//   two-entry queue; the back takes one item at a time from that queue
// - per item the back pops the queue, runs the active-time dividers (one bit
//   per cycle), multiplies, compares against the limit, runs the
//   over-modulation rescale divider only when the limit is exceeded and
//   loads the result register; it takes the next item from the queue only
//   after that result load
// - a stalled receiver holds the result register; the back finishes the next
//   item and waits, and the queue keeps taking items until it is full
// - reset empties the queue and result register and sets bus_voltage to 12 v
`timescale 1ns / 1ps

module svpwm_duty_generator
	import svpwm_pkg::*;
#(
	parameter int VOLT_WIDTH     = VOLT_WIDTH_DEF,
	parameter int DUTY_FRAC_BITS = DUTY_FRAC_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [VOLT_WIDTH-1:0] volt_alpha,
	input  logic signed [VOLT_WIDTH-1:0] volt_beta,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [BUS_W-1:0]             bus_voltage,
	output logic                         empty,
	input  logic                         pop,
	output logic [SECTOR_W-1:0]          sector,
	output logic [DUTY_W-1:0]            duty_high_a,
	output logic [DUTY_W-1:0]            duty_high_b,
	output logic [DUTY_W-1:0]            duty_high_c,
	output logic                         overmod_limited
);

	localparam int PW = VOLT_WIDTH + 19;
	localparam int QW = SECTOR_W + 2 * PW;

	logic [BUS_W-1:0]     bus_q;
	logic [SECTOR_W-1:0]  f_sec;
	logic signed [PW-1:0] f_p1;
	logic signed [PW-1:0] f_p2;
	logic                 q_valid;
	logic                 q_pop;
	logic [QW-1:0]        q_data;

	// bus voltage register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q <= BUS_RESET;
		end else if (cfg_valid) begin
			bus_q <= bus_voltage;
		end
	end

	// classify the vector as it arrives
	svpwm_front #(.VOLT_WIDTH(VOLT_WIDTH), .PW(PW)) u_front (
		.volt_alpha(volt_alpha),
		.volt_beta (volt_beta),
		.sector    (f_sec),
		.proj1     (f_p1),
		.proj2     (f_p2)
	);

	// decouples the accept side from the time engine
	svpwm_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.wr    (push),
		.wdata ({f_sec, f_p1, f_p2}),
		.full  (full),
		.rd    (q_pop),
		.valid (q_valid),
		.rdata (q_data)
	);

	// times, limit, duties and result register
	svpwm_back #(
		.VOLT_WIDTH    (VOLT_WIDTH),
		.DUTY_FRAC_BITS(DUTY_FRAC_BITS),
		.PW            (PW)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.bus            (bus_q),
		.q_valid        (q_valid),
		.q_data         (q_data),
		.q_pop          (q_pop),
		.empty          (empty),
		.pop            (pop),
		.sector         (sector),
		.duty_high_a    (duty_high_a),
		.duty_high_b    (duty_high_b),
		.duty_high_c    (duty_high_c),
		.overmod_limited(overmod_limited)
	);

endmodule
